FILE: rtl/grc_pkg.sv
package grc_pkg;

  // datapath widths
  localparam int CRD_W   = 32;  // signed ray coordinates, 7 fraction bits
  localparam int MUL_A_W = 24;
  localparam int MUL_B_W = 32;
  localparam int PROD_W  = 56;
  localparam int DIST_W  = 20;  // magnitude of a hit offset inside the map
  localparam int SQ_W    = 42;  // squared distance
  localparam int RT_W    = 21;  // distance
  localparam int DIV_N   = 33;
  localparam int DIV_D   = 24;
  localparam int TRIG_W  = 18;  // signed Q16 sin/cos
  localparam int ANG_W   = 12;
  localparam int RAY_W   = 6;
  localparam int STEP_W  = 4;
  localparam int ROM_LAST = 450;

  // angle constants in tenths of a degree
  localparam logic [ANG_W-1:0] ANG_TURN    = 12'd3600;
  localparam logic [ANG_W-1:0] ANG_Q1      = 12'd900;
  localparam logic [ANG_W-1:0] ANG_Q2      = 12'd1800;
  localparam logic [ANG_W-1:0] ANG_Q3      = 12'd2700;
  localparam logic [ANG_W-1:0] ANG_HALF_FOV = 12'd300;
  localparam logic [ANG_W-1:0] ANG_RAY_STEP = 12'd60;

  localparam logic [8:0] SCREEN_H   = 9'd320;
  localparam logic [8:0] SCREEN_MID = 9'd160;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_RENDER = 1'b1;

  localparam logic [2:0] TILE_EMPTY = 3'd0;
  localparam logic [2:0] TILE_GREY  = 3'd1;
  localparam logic [2:0] TILE_RED   = 3'd2;
  localparam logic [2:0] TILE_GREEN = 3'd3;
  localparam logic [2:0] TILE_BLUE  = 3'd4;

  typedef struct packed {
    logic             op;
    logic [5:0]       cell_idx;
    logic [2:0]       tile;
    logic [15:0]      px;
    logic [15:0]      py;
    logic [ANG_W-1:0] pa;
    logic [ANG_W-1:0] ra0;
  } cmd_t;

  typedef struct packed {
    logic [3:0] column;
    logic [7:0] top;
    logic [8:0] bottom;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       vert;
    logic       last;
  } res_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] s;
    logic signed [TRIG_W-1:0] c;
  } sc_t;

  typedef struct packed {
    logic [1:0] q;
    logic       swap;
    logic [8:0] idx;
  } ang_t;

  // {sin, cos} of one octant, Q16
  typedef logic [33:0] trig_rom_t [0:ROM_LAST];

  function automatic trig_rom_t build_trig();
    trig_rom_t rom;
    longint unsigned x, x2, t, sv, cv, one, pi;
    one = 64'd1 << 30;
    pi  = 64'd3373259426;
    for (int r = 0; r <= ROM_LAST; r++) begin
      x  = (longint'(r) * pi) / 1800;
      x2 = (x * x) >> 30;
      t  = one - x2 / 72;
      t  = one - ((x2 * t) >> 30) / 42;
      t  = one - ((x2 * t) >> 30) / 20;
      t  = one - ((x2 * t) >> 30) / 6;
      sv = (((x * t) >> 30) + 8192) >> 14;
      t  = one - x2 / 90;
      t  = one - ((x2 * t) >> 30) / 56;
      t  = one - ((x2 * t) >> 30) / 30;
      t  = one - ((x2 * t) >> 30) / 12;
      t  = one - ((x2 * t) >> 30) / 2;
      cv = (t + 8192) >> 14;
      rom[r] = {sv[16:0], cv[16:0]};
    end
    return rom;
  endfunction

  // quadrant, octant fold and table index of an angle below a full turn
  function automatic ang_t ang_split(logic [ANG_W-1:0] a);
    ang_t o;
    logic [ANG_W-1:0] r;
    if (a >= ANG_Q3) begin
      o.q = 2'd3;
      r = a - ANG_Q3;
    end else if (a >= ANG_Q2) begin
      o.q = 2'd2;
      r = a - ANG_Q2;
    end else if (a >= ANG_Q1) begin
      o.q = 2'd1;
      r = a - ANG_Q1;
    end else begin
      o.q = 2'd0;
      r = a;
    end
    o.swap = (r > ANG_W'(ROM_LAST));
    o.idx  = o.swap ? 9'(ANG_Q1 - r) : r[8:0];
    return o;
  endfunction

  // unfold a table entry into signed sin and cos
  function automatic sc_t trig_map(logic [1:0] q, logic swap, logic [33:0] e);
    sc_t o;
    logic signed [TRIG_W-1:0] a, b;
    a = swap ? {1'b0, e[16:0]} : {1'b0, e[33:17]};
    b = swap ? {1'b0, e[33:17]} : {1'b0, e[16:0]};
    unique case (q)
      2'd0: begin o.s = a;  o.c = b;  end
      2'd1: begin o.s = b;  o.c = -a; end
      2'd2: begin o.s = -a; o.c = -b; end
      default: begin o.s = -b; o.c = a; end
    endcase
    return o;
  endfunction

  // divide a Q16 product by 65536, truncating toward zero
  function automatic logic signed [CRD_W-1:0] tdiv16(logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] adj;
    adj = p + (p[PROD_W-1] ? PROD_W'(65535) : PROD_W'(0));
    return CRD_W'(adj >>> 16);
  endfunction

  // shaded wall colour {red, green, blue}
  function automatic logic [23:0] shade(logic [2:0] tile, logic vert);
    logic [7:0] g, p;
    g = vert ? 8'd150 : 8'd50;
    p = vert ? 8'd250 : 8'd150;
    unique case (tile)
      TILE_GREY:  return {g, g, g};
      TILE_RED:   return {p, 8'd0, 8'd0};
      TILE_GREEN: return {8'd0, p, 8'd0};
      TILE_BLUE:  return {8'd0, 8'd0, p};
      default:    return {8'd200, 8'd0, 8'd200};
    endcase
  endfunction

endpackage

FILE: rtl/grc_fifo.sv
module grc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wp_r, rp_r;
  logic [PW:0]      cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == (PW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rp_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= (wp_r == PW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (do_pop)  rp_r <= (rp_r == PW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= din;
  end

endmodule

FILE: rtl/grc_front.sv
module grc_front #(
  parameter int CELLS = 64
) (
  input  logic          in_push,
  output logic          in_full,
  input  logic          in_opcode,
  input  logic [5:0]    in_cell_index,
  input  logic [2:0]    in_tile_code,
  input  logic [15:0]   in_player_x,
  input  logic [15:0]   in_player_y,
  input  logic [11:0]   in_player_angle,
  input  logic          q_full,
  output logic          q_push,
  output grc_pkg::cmd_t q_data
);

  logic [grc_pkg::ANG_W-1:0] pa;
  logic                      keep;

  // angle taken modulo a full turn, first ray angle
  assign pa = (in_player_angle >= grc_pkg::ANG_TURN) ?
              in_player_angle - grc_pkg::ANG_TURN : in_player_angle;

  always_comb begin
    q_data.op       = in_opcode;
    q_data.cell_idx = in_cell_index;
    q_data.tile     = in_tile_code;
    q_data.px       = in_player_x;
    q_data.py       = in_player_y;
    q_data.pa       = pa;
    q_data.ra0      = (pa >= grc_pkg::ANG_HALF_FOV) ? pa - grc_pkg::ANG_HALF_FOV :
                      pa + (grc_pkg::ANG_TURN - grc_pkg::ANG_HALF_FOV);
  end

  // writes outside the map are dropped here
  assign keep    = (in_opcode == grc_pkg::OP_RENDER) || (32'(in_cell_index) < 32'(CELLS));
  assign in_full = q_full;
  assign q_push  = in_push && !q_full && keep;

endmodule

FILE: rtl/grc_div.sv
module grc_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [grc_pkg::DIV_N-1:0] num,
  input  logic [grc_pkg::DIV_D-1:0] den,
  output logic                      done,
  output logic [grc_pkg::DIV_N-1:0] quot
);

  localparam int N = grc_pkg::DIV_N;
  localparam int D = grc_pkg::DIV_D;

  logic         busy_r, done_r;
  logic [5:0]   cnt_r;
  logic [D-1:0] rem_r, den_r;
  logic [N-1:0] q_r;
  logic [D:0]   sh;
  logic         ge;

  assign sh   = {rem_r, q_r[N-1]};
  assign ge   = (sh >= {1'b0, den_r});
  assign done = done_r;
  assign quot = q_r;

  // restoring divide, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'(N);
        rem_r  <= '0;
        q_r    <= num;
        den_r  <= den;
      end else if (busy_r) begin
        rem_r <= ge ? D'(sh - {1'b0, den_r}) : sh[D-1:0];
        q_r   <= {q_r[N-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/grc_back.sv
module grc_back #(
  parameter int MAP_WIDTH  = 8,
  parameter int MAP_HEIGHT = 8,
  parameter int TILE_SHIFT = 6,
  parameter int RAY_COUNT  = 10,
  parameter int MAX_STEPS  = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  grc_pkg::cmd_t cmd,
  output logic          cmd_pop,
  input  logic          res_full,
  output logic          res_push,
  output grc_pkg::res_t res
);

  localparam int CELLS    = MAP_WIDTH * MAP_HEIGHT;
  localparam int AW       = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int TSH      = TILE_SHIFT + 7;
  localparam int TILE_RAW = 1 << TSH;
  localparam int CW       = grc_pkg::CRD_W;
  localparam int RW       = grc_pkg::RT_W;
  localparam int SQW      = grc_pkg::SQ_W;
  localparam grc_pkg::trig_rom_t TRIG_ROM = grc_pkg::build_trig();

  typedef enum logic [4:0] {
    S_IDLE, S_TRIG, S_TRIG_W, S_HDIV, S_HM1, S_HM2, S_HM3,
    S_VSTART, S_VDIV, S_VM1, S_VM2, S_VM3,
    S_WADDR, S_WCHK, S_SQ1, S_SQ2, S_SQ3, S_SQRT,
    S_SEL, S_CTRIG, S_CTRIG_W, S_CM1, S_CM2, S_HTDIV, S_OUT
  } state_t;

  state_t state_r;

  // frame and ray registers
  logic [15:0]                 px_r, py_r;
  logic [grc_pkg::ANG_W-1:0]   pa_r, ra_r;
  logic [grc_pkg::RAY_W-1:0]   ray_r;
  logic signed [CW-1:0]        base_x_r, base_y_r;
  logic signed [grc_pkg::TRIG_W-1:0] s_r, c_r;
  logic signed [CW-1:0]        cot_r;

  // walker
  logic signed [CW-1:0]        wx_r, wy_r, wxo_r, wyo_r;
  logic [grc_pkg::STEP_W-1:0]  step_r;
  logic                        axis_v_r;
  logic [2:0]                  hit_tile_r;

  // per-axis results and selection
  logic                        hh_r, hv_r, vert_r, any_r;
  logic [RW-1:0]               dh_r, dv_r, dist_r;
  logic [2:0]                  th_r, tv_r, tile_r;
  logic [8:0]                  height_r;

  // shared multiplier
  logic signed [grc_pkg::MUL_A_W-1:0] mul_a_r;
  logic signed [grc_pkg::MUL_B_W-1:0] mul_b_r;
  logic signed [grc_pkg::PROD_W-1:0]  prod_r;

  // square root
  logic [SQW-1:0] sq_n_r, sq_res_r, sq_bit_r;

  // divider control
  logic                        div_go_r, div_done;
  logic [grc_pkg::DIV_N-1:0]   div_num_r, div_quot;
  logic [grc_pkg::DIV_D-1:0]   div_den_r;

  // table and map reads
  logic [33:0]                 rom_q_r;
  logic [1:0]                  rq_r;
  logic                        rswap_r;
  logic [2:0]                  store_r [CELLS];
  logic [CELLS-1:0]            vld_r;
  logic [2:0]                  st_q_r;
  logic                        stv_r, inmap_r;

  // combinational helpers
  logic [grc_pkg::ANG_W-1:0]   cang, lk_ang, ra_next;
  grc_pkg::ang_t               asp;
  grc_pkg::sc_t                sc;
  logic signed [CW-1:0]        px32, py32, cot_c, ry_h, yo_h, rx_v, xo_v, dxs, dys;
  logic [CW-1:0]               mx_u, my_u;
  logic                        inmap;
  logic [AW-1:0]               raddr;
  logic [2:0]                  tile_seen;
  logic [grc_pkg::DIST_W-1:0]  dxa, dya;
  logic [SQW-1:0]              sq_sum, sq_res_n, sq_n_n;
  logic                        sq_ge;
  logic                        st_we;
  logic [16:0]                 abs_s, abs_c;
  logic                        vert_c;
  logic [23:0]                 rgb;
  logic [8:0]                  top9;

  assign px32 = signed'(CW'(px_r));
  assign py32 = signed'(CW'(py_r));

  // view-relative angle for the fisheye term
  assign cang    = (pa_r >= ra_r) ? pa_r - ra_r : pa_r + (grc_pkg::ANG_TURN - ra_r);
  assign lk_ang  = (state_r == S_CTRIG) ? cang : ra_r;
  assign asp     = grc_pkg::ang_split(lk_ang);
  assign sc      = grc_pkg::trig_map(rq_r, rswap_r, rom_q_r);
  assign ra_next = (ra_r >= grc_pkg::ANG_TURN - grc_pkg::ANG_RAY_STEP) ?
                   ra_r - (grc_pkg::ANG_TURN - grc_pkg::ANG_RAY_STEP) :
                   ra_r + grc_pkg::ANG_RAY_STEP;

  // sin/cos table read
  always_ff @(posedge clk) begin
    rom_q_r <= TRIG_ROM[asp.idx];
    rq_r    <= asp.q;
    rswap_r <= asp.swap;
  end

  // signed quotient and axis start points
  assign abs_s = s_r[grc_pkg::TRIG_W-1] ? 17'(-s_r) : 17'(s_r);
  assign abs_c = c_r[grc_pkg::TRIG_W-1] ? 17'(-c_r) : 17'(c_r);
  assign cot_c = (s_r[grc_pkg::TRIG_W-1] ^ c_r[grc_pkg::TRIG_W-1]) ?
                 -signed'(CW'(div_quot)) : signed'(CW'(div_quot));
  assign ry_h  = (ra_r > grc_pkg::ANG_Q2) ? base_y_r - CW'(1) : base_y_r + CW'(TILE_RAW);
  assign yo_h  = (ra_r > grc_pkg::ANG_Q2) ? -CW'(TILE_RAW) : CW'(TILE_RAW);
  assign rx_v  = (ra_r > grc_pkg::ANG_Q1 && ra_r < grc_pkg::ANG_Q3) ?
                 base_x_r - CW'(1) : base_x_r + CW'(TILE_RAW);
  assign xo_v  = (ra_r > grc_pkg::ANG_Q1 && ra_r < grc_pkg::ANG_Q3) ?
                 -CW'(TILE_RAW) : CW'(TILE_RAW);

  // map cell of the current crossing
  assign mx_u  = wx_r >> TSH;
  assign my_u  = wy_r >> TSH;
  assign inmap = !wx_r[CW-1] && !wy_r[CW-1] &&
                 (mx_u < CW'(MAP_WIDTH)) && (my_u < CW'(MAP_HEIGHT));
  assign raddr = inmap ? AW'(my_u * CW'(MAP_WIDTH) + mx_u) : '0;
  assign tile_seen = stv_r ? st_q_r : grc_pkg::TILE_EMPTY;

  assign dxs = wx_r - px32;
  assign dys = wy_r - py32;
  assign dxa = dxs[CW-1] ? grc_pkg::DIST_W'(-dxs) : grc_pkg::DIST_W'(dxs);
  assign dya = dys[CW-1] ? grc_pkg::DIST_W'(-dys) : grc_pkg::DIST_W'(dys);

  // one square root step
  assign sq_sum   = sq_res_r + sq_bit_r;
  assign sq_ge    = (sq_n_r >= sq_sum);
  assign sq_n_n   = sq_ge ? sq_n_r - sq_sum : sq_n_r;
  assign sq_res_n = sq_ge ? (sq_res_r >> 1) + sq_bit_r : sq_res_r >> 1;

  assign vert_c = hv_r && (!hh_r || dv_r < dh_r);

  // tile map: write port and registered read
  assign st_we   = (state_r == S_IDLE) && cmd_valid && (cmd.op == grc_pkg::OP_WRITE);
  assign cmd_pop = (state_r == S_IDLE) && cmd_valid;

  always_ff @(posedge clk) begin
    if (st_we) store_r[AW'(cmd.cell_idx)] <= cmd.tile;
    st_q_r  <= store_r[raddr];
    stv_r   <= vld_r[raddr];
    inmap_r <= inmap;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (st_we) begin
      vld_r[AW'(cmd.cell_idx)] <= 1'b1;
    end
  end

  // multiplier stage
  always_ff @(posedge clk) begin
    prod_r <= mul_a_r * mul_b_r;
  end

  grc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go_r),
    .num   (div_num_r),
    .den   (div_den_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  // ray sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      div_go_r <= 1'b0;
    end else begin
      div_go_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (cmd_valid && cmd.op == grc_pkg::OP_RENDER) begin
            px_r     <= cmd.px;
            py_r     <= cmd.py;
            pa_r     <= cmd.pa;
            ra_r     <= cmd.ra0;
            ray_r    <= '0;
            base_x_r <= signed'((CW'(cmd.px) >> TSH) << TSH);
            base_y_r <= signed'((CW'(cmd.py) >> TSH) << TSH);
            state_r  <= S_TRIG;
          end
        end
        S_TRIG: state_r <= S_TRIG_W;
        S_TRIG_W: begin
          s_r  <= sc.s;
          c_r  <= sc.c;
          hh_r <= 1'b0;
          hv_r <= 1'b0;
          if (ra_r != '0 && ra_r != grc_pkg::ANG_Q2 && sc.s != '0) begin
            div_num_r <= {(sc.c[grc_pkg::TRIG_W-1] ? 17'(-sc.c) : 17'(sc.c)), 16'd0};
            div_den_r <= grc_pkg::DIV_D'(sc.s[grc_pkg::TRIG_W-1] ? 17'(-sc.s) : 17'(sc.s));
            div_go_r  <= 1'b1;
            state_r   <= S_HDIV;
          end else begin
            state_r <= S_VSTART;
          end
        end
        S_HDIV: begin
          if (div_done) begin
            cot_r    <= cot_c;
            wy_r     <= ry_h;
            wyo_r    <= yo_h;
            step_r   <= '0;
            axis_v_r <= 1'b0;
            mul_a_r  <= grc_pkg::MUL_A_W'(ry_h - py32);
            mul_b_r  <= cot_c;
            state_r  <= S_HM1;
          end
        end
        S_HM1: begin
          mul_a_r <= grc_pkg::MUL_A_W'(wyo_r);
          mul_b_r <= cot_r;
          state_r <= S_HM2;
        end
        S_HM2: begin
          wx_r    <= px32 + grc_pkg::tdiv16(prod_r);
          state_r <= S_HM3;
        end
        S_HM3: begin
          wxo_r   <= grc_pkg::tdiv16(prod_r);
          state_r <= S_WADDR;
        end
        S_VSTART: begin
          if (ra_r != grc_pkg::ANG_Q1 && ra_r != grc_pkg::ANG_Q3 && c_r != '0) begin
            div_num_r <= {abs_s, 16'd0};
            div_den_r <= grc_pkg::DIV_D'(abs_c);
            div_go_r  <= 1'b1;
            state_r   <= S_VDIV;
          end else begin
            state_r <= S_SEL;
          end
        end
        S_VDIV: begin
          if (div_done) begin
            cot_r    <= cot_c;
            wx_r     <= rx_v;
            wxo_r    <= xo_v;
            step_r   <= '0;
            axis_v_r <= 1'b1;
            mul_a_r  <= grc_pkg::MUL_A_W'(rx_v - px32);
            mul_b_r  <= cot_c;
            state_r  <= S_VM1;
          end
        end
        S_VM1: begin
          mul_a_r <= grc_pkg::MUL_A_W'(wxo_r);
          mul_b_r <= cot_r;
          state_r <= S_VM2;
        end
        S_VM2: begin
          wy_r    <= py32 + grc_pkg::tdiv16(prod_r);
          state_r <= S_VM3;
        end
        S_VM3: begin
          wyo_r   <= grc_pkg::tdiv16(prod_r);
          state_r <= S_WADDR;
        end
        S_WADDR: state_r <= S_WCHK;
        S_WCHK: begin
          if (inmap_r && tile_seen != grc_pkg::TILE_EMPTY) begin
            hit_tile_r <= tile_seen;
            mul_a_r    <= signed'(grc_pkg::MUL_A_W'(dxa));
            mul_b_r    <= signed'(grc_pkg::MUL_B_W'(dxa));
            state_r    <= S_SQ1;
          end else if (step_r == grc_pkg::STEP_W'(MAX_STEPS - 1)) begin
            state_r <= axis_v_r ? S_SEL : S_VSTART;
          end else begin
            wx_r    <= wx_r + wxo_r;
            wy_r    <= wy_r + wyo_r;
            step_r  <= step_r + 1'b1;
            state_r <= S_WADDR;
          end
        end
        S_SQ1: begin
          mul_a_r <= signed'(grc_pkg::MUL_A_W'(dya));
          mul_b_r <= signed'(grc_pkg::MUL_B_W'(dya));
          state_r <= S_SQ2;
        end
        S_SQ2: begin
          sq_n_r  <= SQW'(prod_r);
          state_r <= S_SQ3;
        end
        S_SQ3: begin
          sq_n_r   <= sq_n_r + SQW'(prod_r);
          sq_res_r <= '0;
          sq_bit_r <= SQW'(1) << (SQW - 2);
          state_r  <= S_SQRT;
        end
        S_SQRT: begin
          sq_n_r   <= sq_n_n;
          sq_res_r <= sq_res_n;
          sq_bit_r <= sq_bit_r >> 2;
          if (sq_bit_r[0]) begin
            if (axis_v_r) begin
              hv_r    <= 1'b1;
              dv_r    <= RW'(sq_res_n);
              tv_r    <= hit_tile_r;
              state_r <= S_SEL;
            end else begin
              hh_r    <= 1'b1;
              dh_r    <= RW'(sq_res_n);
              th_r    <= hit_tile_r;
              state_r <= S_VSTART;
            end
          end
        end
        S_SEL: begin
          vert_r <= vert_c;
          any_r  <= vert_c || hh_r;
          dist_r <= vert_c ? dv_r : dh_r;
          tile_r <= vert_c ? tv_r : th_r;
          if (vert_c || hh_r) begin
            state_r <= S_CTRIG;
          end else begin
            height_r <= '0;
            state_r  <= S_OUT;
          end
        end
        S_CTRIG: state_r <= S_CTRIG_W;
        S_CTRIG_W: begin
          if (sc.c[grc_pkg::TRIG_W-1] || sc.c == '0) begin
            height_r <= grc_pkg::SCREEN_H;
            state_r  <= S_OUT;
          end else begin
            mul_a_r <= signed'(grc_pkg::MUL_A_W'(dist_r));
            mul_b_r <= grc_pkg::MUL_B_W'(sc.c);
            state_r <= S_CM1;
          end
        end
        S_CM1: state_r <= S_CM2;
        S_CM2: begin
          if ((prod_r >>> 16) == '0) begin
            height_r <= grc_pkg::SCREEN_H;
            state_r  <= S_OUT;
          end else begin
            div_num_r <= grc_pkg::DIV_N'(320 * TILE_RAW);
            div_den_r <= grc_pkg::DIV_D'(prod_r >>> 16);
            div_go_r  <= 1'b1;
            state_r   <= S_HTDIV;
          end
        end
        S_HTDIV: begin
          if (div_done) begin
            height_r <= (div_quot > grc_pkg::DIV_N'(grc_pkg::SCREEN_H)) ?
                        grc_pkg::SCREEN_H : div_quot[8:0];
            state_r  <= S_OUT;
          end
        end
        S_OUT: begin
          if (!res_full) begin
            ra_r  <= ra_next;
            ray_r <= ray_r + 1'b1;
            state_r <= (ray_r == grc_pkg::RAY_W'(RAY_COUNT - 1)) ? S_IDLE : S_TRIG;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // result assembly
  assign rgb      = any_r ? grc_pkg::shade(tile_r, vert_r) : 24'd0;
  assign top9     = grc_pkg::SCREEN_MID - {1'b0, height_r[8:1]};
  assign res_push = (state_r == S_OUT) && !res_full;

  always_comb begin
    res.column = ray_r[3:0];
    res.top    = top9[7:0];
    res.bottom = top9 + height_r;
    res.red    = rgb[23:16];
    res.green  = rgb[15:8];
    res.blue   = rgb[7:0];
    res.vert   = vert_r && any_r;
    res.last   = (ray_r == grc_pkg::RAY_W'(RAY_COUNT - 1));
  end

endmodule

FILE: rtl/grid_raycast_wall_columns.sv
// Grid raycaster: an item either writes one cell of the tile map (no result) or
// renders one frame, which returns RAY_COUNT wall columns in ray order, the
// last one flagged. Items enter a two-deep command queue and columns leave
// through a two-deep result queue, so both sides may stall freely. The ray
// engine handles one item at a time and takes the next only once back in
// idle; a render's time per ray is set by the shared one-bit-per-cycle
// divider (up to three divides per ray), the 21-step square root per wall
// hit and the registered map read at each grid crossing. The map resets
// to empty at once through per-cell valid bits; no clearing pass is needed.
module grid_raycast_wall_columns #(
  parameter int MAP_WIDTH  = 8,
  parameter int MAP_HEIGHT = 8,
  parameter int TILE_SHIFT = 6,
  parameter int RAY_COUNT  = 10,
  parameter int MAX_STEPS  = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_opcode,
  input  logic [5:0]  in_cell_index,
  input  logic [2:0]  in_tile_code,
  input  logic [15:0] in_player_x,
  input  logic [15:0] in_player_y,
  input  logic [11:0] in_player_angle,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [3:0]  out_column,
  output logic [7:0]  out_line_top,
  output logic [8:0]  out_line_bottom,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        out_hit_vertical,
  output logic        out_last
);

  localparam int CW = $bits(grc_pkg::cmd_t);
  localparam int RW = $bits(grc_pkg::res_t);

  grc_pkg::cmd_t    fq_data, cmd;
  grc_pkg::res_t    res, res_out;
  logic             fq_push, fq_full, cmd_empty, cmd_pop;
  logic             res_push, res_full;
  logic [CW-1:0]    cmd_bits;
  logic [RW-1:0]    res_bits;

  // front: classify and queue
  grc_front #(.CELLS(MAP_WIDTH * MAP_HEIGHT)) u_front (
    .in_push         (in_push),
    .in_full         (in_full),
    .in_opcode       (in_opcode),
    .in_cell_index   (in_cell_index),
    .in_tile_code    (in_tile_code),
    .in_player_x     (in_player_x),
    .in_player_y     (in_player_y),
    .in_player_angle (in_player_angle),
    .q_full          (fq_full),
    .q_push          (fq_push),
    .q_data          (fq_data)
  );

  grc_fifo #(.WIDTH(CW), .DEPTH(2)) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fq_push),
    .din   (fq_data),
    .full  (fq_full),
    .pop   (cmd_pop),
    .dout  (cmd_bits),
    .empty (cmd_empty)
  );

  assign cmd = grc_pkg::cmd_t'(cmd_bits);

  // back: ray engine
  grc_back #(
    .MAP_WIDTH  (MAP_WIDTH),
    .MAP_HEIGHT (MAP_HEIGHT),
    .TILE_SHIFT (TILE_SHIFT),
    .RAY_COUNT  (RAY_COUNT),
    .MAX_STEPS  (MAX_STEPS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!cmd_empty),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  grc_fifo #(.WIDTH(RW), .DEPTH(2)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (res_bits),
    .empty (out_empty)
  );

  assign res_out          = grc_pkg::res_t'(res_bits);
  assign out_column       = res_out.column;
  assign out_line_top     = res_out.top;
  assign out_line_bottom  = res_out.bottom;
  assign out_red          = res_out.red;
  assign out_green        = res_out.green;
  assign out_blue         = res_out.blue;
  assign out_hit_vertical = res_out.vert;
  assign out_last         = res_out.last;

endmodule

FILE: rtl/grc_chk.sv
module grc_chk #(
  parameter int RAY_COUNT = 10
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_push,
  input logic        in_full,
  input logic        in_opcode,
  input logic [5:0]  in_cell_index,
  input logic [2:0]  in_tile_code,
  input logic [15:0] in_player_x,
  input logic [15:0] in_player_y,
  input logic [11:0] in_player_angle,
  input logic        out_empty,
  input logic        out_pop,
  input logic [3:0]  out_column,
  input logic [7:0]  out_line_top,
  input logic [8:0]  out_line_bottom,
  input logic [7:0]  out_red,
  input logic [7:0]  out_green,
  input logic [7:0]  out_blue,
  input logic        out_hit_vertical,
  input logic        out_last
);

  // queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  // a waiting column stays until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty)
    else $error("result dropped without transfer");

  // the line is centred on the screen middle
  a_centre: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (10'(out_line_bottom) + 10'(out_line_top) == 10'd320) ||
                   (10'(out_line_bottom) + 10'(out_line_top) == 10'd321))
    else $error("wall line not centred");

  // frame end lines up with the last ray
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_last |-> out_column == 4'(RAY_COUNT - 1))
    else $error("last flag on wrong column");

  // a vertical hit always has a coloured wall
  a_vert_colour: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_hit_vertical |-> (out_red | out_green | out_blue) != 8'd0)
    else $error("vertical hit without colour");

endmodule

bind grid_raycast_wall_columns grc_chk #(.RAY_COUNT(RAY_COUNT)) u_chk (.*);

FILE: test/tb_grid_raycast_wall_columns.sv
module tb_grid_raycast_wall_columns;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int MAP_CELLS   = 64;
  localparam int TILE_BITS   = 13;
  localparam longint TILE_UNITS = 64'sd8192;
  localparam int RAYS = 10;

  typedef struct {
    logic        op;
    logic [5:0]  cell_idx;
    logic [2:0]  tile;
    logic [15:0] px;
    logic [15:0] py;
    logic [11:0] ang;
  } ray_cmd_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic        in_opcode = 1'b0;
  logic [5:0]  in_cell_index = '0;
  logic [2:0]  in_tile_code = '0;
  logic [15:0] in_player_x = '0;
  logic [15:0] in_player_y = '0;
  logic [11:0] in_player_angle = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [3:0]  out_column;
  logic [7:0]  out_line_top;
  logic [8:0]  out_line_bottom;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic        out_hit_vertical;
  logic        out_last;

  // predictor state and expected columns
  logic [2:0]    map_cells [MAP_CELLS];
  grc_pkg::res_t column_q [$];

  int  mismatch_cnt = 0;
  int  column_cnt = 0;
  int  render_cnt = 0;
  int  write_cnt = 0;
  int  cycle_cnt = 0;
  int  hold_left = 0;
  bit  no_idle = 1'b0;
  bit  saw_full = 1'b0;

  grid_raycast_wall_columns uut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_opcode(in_opcode), .in_cell_index(in_cell_index),
    .in_tile_code(in_tile_code), .in_player_x(in_player_x),
    .in_player_y(in_player_y), .in_player_angle(in_player_angle),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_column(out_column), .out_line_top(out_line_top),
    .out_line_bottom(out_line_bottom), .out_red(out_red),
    .out_green(out_green), .out_blue(out_blue),
    .out_hit_vertical(out_hit_vertical), .out_last(out_last)
  );

  always #2 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (in_push && in_full) saw_full = 1'b1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d columns outstanding", cycle_cnt, column_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // one octant of sin and cos, Q16, Horner on Q30
  task automatic octant_trig(input int unsigned r, output longint sv, output longint cv);
    longint unsigned x, x2, t, one;
    one = 64'd1 << 30;
    x  = (longint'(r) * 64'd3373259426) / 1800;
    x2 = (x * x) >> 30;
    t  = one - x2 / 72;
    t  = one - ((x2 * t) >> 30) / 42;
    t  = one - ((x2 * t) >> 30) / 20;
    t  = one - ((x2 * t) >> 30) / 6;
    sv = longint'((((x * t) >> 30) + 8192) >> 14);
    t  = one - x2 / 90;
    t  = one - ((x2 * t) >> 30) / 56;
    t  = one - ((x2 * t) >> 30) / 30;
    t  = one - ((x2 * t) >> 30) / 12;
    t  = one - ((x2 * t) >> 30) / 2;
    cv = longint'((t + 8192) >> 14);
  endtask

  task automatic angle_trig(input int unsigned a, output longint s, output longint c);
    int unsigned q, r;
    longint s0, c0;
    q = (a % 3600) / 900;
    r = a % 900;
    if (r <= 450) octant_trig(r, s0, c0);
    else octant_trig(900 - r, c0, s0);
    case (q)
      0: begin s = s0;  c = c0;  end
      1: begin s = c0;  c = -s0; end
      2: begin s = -s0; c = -c0; end
      default: begin s = -c0; c = s0; end
    endcase
  endtask

  function automatic longint floor_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  // step along grid crossings until a non-empty cell
  task automatic march_ray(input longint rx, input longint ry, input longint xo,
                           input longint yo, input longint px, input longint py,
                           output bit hit, output longint hit_dist, output logic [2:0] tile);
    longint mx, my, dx, dy;
    hit = 1'b0;
    hit_dist = 0;
    tile = grc_pkg::TILE_EMPTY;
    for (int i = 0; i < 8; i++) begin
      if (!hit && rx >= 0 && ry >= 0) begin
        mx = rx >>> TILE_BITS;
        my = ry >>> TILE_BITS;
        if (mx < 8 && my < 8 && map_cells[my * 8 + mx] != grc_pkg::TILE_EMPTY) begin
          dx = rx - px;
          dy = ry - py;
          if (dx < 0) dx = -dx;
          if (dy < 0) dy = -dy;
          hit_dist = floor_sqrt(longint'(dx * dx + dy * dy));
          tile = map_cells[my * 8 + mx];
          hit = 1'b1;
        end
      end
      rx += xo;
      ry += yo;
    end
  endtask

  // expected wall columns of one frame
  task automatic render_frame(input ray_cmd_t c);
    longint px, py, bx, by, s, co, cs, cc, cot, tn, rx, ry, xo, yo;
    longint dh, dv, wall_dist, corr, height, top;
    int unsigned pa, ra;
    logic [2:0] th, tv, tile;
    bit hh, hv, vert;
    int sh, red, grn, blu;
    grc_pkg::res_t e;
    px = longint'(c.px);
    py = longint'(c.py);
    pa = int'(c.ang) % 3600;
    bx = (px >>> TILE_BITS) <<< TILE_BITS;
    by = (py >>> TILE_BITS) <<< TILE_BITS;
    ra = (pa + 3600 - 300) % 3600;
    for (int r = 0; r < RAYS; r++) begin
      hh = 1'b0;
      hv = 1'b0;
      dh = 0;
      dv = 0;
      th = grc_pkg::TILE_EMPTY;
      tv = grc_pkg::TILE_EMPTY;
      red = 0;
      grn = 0;
      blu = 0;
      angle_trig(ra, s, co);
      // horizontal grid lines
      if (ra != 0 && ra != 1800 && s != 0) begin
        cot = (co * 65536) / s;
        if (ra > 1800) begin
          ry = by - 1;
          yo = -TILE_UNITS;
        end else begin
          ry = by + TILE_UNITS;
          yo = TILE_UNITS;
        end
        march_ray(px + ((ry - py) * cot) / 65536, ry, (yo * cot) / 65536, yo,
                  px, py, hh, dh, th);
      end
      // vertical grid lines
      if (ra != 900 && ra != 2700 && co != 0) begin
        tn = (s * 65536) / co;
        if (ra > 900 && ra < 2700) begin
          rx = bx - 1;
          xo = -TILE_UNITS;
        end else begin
          rx = bx + TILE_UNITS;
          xo = TILE_UNITS;
        end
        march_ray(rx, py + ((rx - px) * tn) / 65536, xo, (xo * tn) / 65536,
                  px, py, hv, dv, tv);
      end
      vert = hv && (!hh || dv < dh);
      if (vert || hh) begin
        wall_dist = vert ? dv : dh;
        tile = vert ? tv : th;
        angle_trig((pa + 3600 - ra) % 3600, cs, cc);
        corr = (wall_dist * cc) / 65536;
        if (corr <= 0) height = 320;
        else begin
          height = (64'sd320 * TILE_UNITS) / corr;
          if (height > 320) height = 320;
        end
        sh = vert ? 50 : -50;
        case (tile)
          grc_pkg::TILE_GREY:  begin red = 100 + sh; grn = 100 + sh; blu = 100 + sh; end
          grc_pkg::TILE_RED:   red = 200 + sh;
          grc_pkg::TILE_GREEN: grn = 200 + sh;
          grc_pkg::TILE_BLUE:  blu = 200 + sh;
          default:    begin red = 200; blu = 200; end
        endcase
      end else begin
        height = 0;
      end
      top = 160 - height / 2;
      e.column = r[3:0];
      e.top    = top[7:0];
      e.bottom = 9'(top + height);
      e.red    = red[7:0];
      e.green  = grn[7:0];
      e.blue   = blu[7:0];
      e.vert   = vert;
      e.last   = (r == RAYS - 1);
      column_q.push_back(e);
      ra = (ra + 60) % 3600;
    end
  endtask

  function automatic int idle_draw();
    return no_idle ? 0 : $urandom_range(0, 18);
  endfunction

  // offer one item and wait for its transfer
  task automatic send_item(input ray_cmd_t c);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_opcode <= c.op;
    in_cell_index <= c.cell_idx;
    in_tile_code <= c.tile;
    in_player_x <= c.px;
    in_player_y <= c.py;
    in_player_angle <= c.ang;
    do @(posedge clk); while (in_full);
    if (c.op == grc_pkg::OP_WRITE) begin
      map_cells[c.cell_idx] = c.tile;
      write_cnt++;
    end else begin
      render_frame(c);
      render_cnt++;
    end
  endtask

  task automatic write_cell(input int idx, input int tile);
    ray_cmd_t c;
    c.op = grc_pkg::OP_WRITE;
    c.cell_idx = 6'(idx);
    c.tile = 3'(tile);
    c.px = 16'($urandom);
    c.py = 16'($urandom);
    c.ang = 12'($urandom);
    send_item(c);
  endtask

  task automatic render_at(input int px, input int py, input int ang);
    ray_cmd_t c;
    c.op = grc_pkg::OP_RENDER;
    c.cell_idx = 6'($urandom);
    c.tile = 3'($urandom);
    c.px = 16'(px);
    c.py = 16'(py);
    c.ang = 12'(ang);
    send_item(c);
  endtask

  // result side: draw stalls, apply hold-off, check each transfer
  initial begin
    int wait_left;
    grc_pkg::res_t got, e;
    wait_left = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (out_pop && !out_empty) begin
        got = '{out_column, out_line_top, out_line_bottom, out_red, out_green,
                out_blue, out_hit_vertical, out_last};
        column_cnt++;
        if (column_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected column %0d top %0d bottom %0d", got.column, got.top,
                     got.bottom);
        end else begin
          e = column_q.pop_front();
          if (got.column !== e.column || got.top !== e.top || got.bottom !== e.bottom ||
              got.red !== e.red || got.green !== e.green || got.blue !== e.blue ||
              got.vert !== e.vert || got.last !== e.last) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("column mismatch exp col %0d top %0d bot %0d rgb %0d,%0d,%0d v %0b l %0b",
                       e.column, e.top, e.bottom, e.red, e.green, e.blue, e.vert, e.last);
              $display("                got col %0d top %0d bot %0d rgb %0d,%0d,%0d v %0b l %0b",
                       got.column, got.top, got.bottom, got.red, got.green, got.blue,
                       got.vert, got.last);
            end
          end
        end
        wait_left = idle_draw();
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else if (wait_left > 0) begin
        wait_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // empty map: every ray misses, extremes of position and angle
  task automatic test_empty_map();
    render_at(0, 0, 0);
    render_at(65535, 65535, 4095);
    render_at(32768, 16384, 3599);
  endtask

  // corner and border cells, every tile code, axis-parallel rays
  task automatic test_directed();
    write_cell(0, 1);
    write_cell(63, 7);
    write_cell(7, 2);
    write_cell(56, 3);
    write_cell(3, 4);
    write_cell(24, 5);
    write_cell(31, 6);
    write_cell(60, 2);
    write_cell(60, 0);
    render_at(32768, 32768, 0);
    render_at(32768, 32768, 900);
    render_at(32768, 32768, 1800);
    render_at(32768, 32768, 2700);
    render_at(8192, 8192, 2250);
    render_at(0, 0, 450);
    render_at(65535, 65535, 2250);
    render_at(8191, 8192, 3600);
    render_at(4096, 4096, 1350);
    render_at(12345, 54321, 3000);
  endtask

  // wall layouts built from writes, then a frame
  task automatic test_random_frames(input int rounds);
    int k, ang, sel;
    for (int n = 0; n < rounds; n++) begin
      no_idle = (n % 20) >= 16;
      k = $urandom_range(1, 6);
      for (int j = 0; j < k; j++)
        write_cell($urandom_range(0, 63),
                   ($urandom_range(0, 9) < 7) ? $urandom_range(1, 7) : 0);
      sel = $urandom_range(0, 19);
      if (sel < 2) ang = $urandom_range(3600, 4095);
      else if (sel < 5) ang = 60 * $urandom_range(0, 59);
      else ang = $urandom_range(0, 3599);
      render_at($urandom_range(0, 65535), $urandom_range(0, 65535), ang);
    end
    no_idle = 1'b0;
  endtask

  // receiver holds off while frames keep coming, so the input stalls
  task automatic test_backpressure();
    no_idle = 1'b1;
    hold_left = 4000;
    for (int n = 0; n < 5; n++)
      render_at($urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 3599));
    no_idle = 1'b0;
  endtask

  // sender pauses until every column is out, then resumes
  task automatic test_drain_pause();
    in_push <= 1'b0;
    @(posedge clk);
    while (column_q.size() > 0) @(posedge clk);
    for (int n = 0; n < 4; n++) begin
      write_cell($urandom_range(0, 63), $urandom_range(1, 7));
      render_at($urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 4095));
    end
  endtask

  initial begin
    for (int i = 0; i < MAP_CELLS; i++) map_cells[i] = grc_pkg::TILE_EMPTY;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_map();
    test_directed();
    test_random_frames(44);
    test_backpressure();
    test_random_frames(44);
    test_drain_pause();
    in_push <= 1'b0;
    while (column_q.size() > 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (column_q.size() != 0) mismatch_cnt++;
    $display("%0d frames and %0d cell writes sent, %0d columns checked, %0d mismatches",
             render_cnt, write_cnt, column_cnt, mismatch_cnt);
    $display("input stall seen: %0b, receiver hold-off and drain pause exercised", saw_full);
    if (mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/grc_pkg.sv
rtl/grc_fifo.sv
rtl/grc_front.sv
rtl/grc_div.sv
rtl/grc_back.sv
rtl/grid_raycast_wall_columns.sv
rtl/grc_chk.sv
test/tb_grid_raycast_wall_columns.sv
